// ----- src/sap_pkg.sv -----
// Shared types, constants and helper functions of the swept all-pass phaser.
package sap_pkg;

   localparam int STAGES      = 4;
   localparam int STAGE_W     = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int MEM_DEPTH   = 2 * STAGES;
   localparam int MEM_W       = $clog2(MEM_DEPTH);
   localparam int SAMPLE_BITS = 24;
   localparam int MUL_W       = 33;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int DIV_W       = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWEEP_DEPTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_LOG2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOOR_LOG2    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_GAIN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WET_MIX       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGHPASS_COEF = 3'd6;

   localparam logic signed [19:0] CEIL_LOG2 = -20'sd9437;
   localparam logic signed [19:0] LOG_BIAS  = 20'sd139264;

   // quarter-wave sine polynomial, Q30
   localparam logic signed [MUL_W-1:0] SIN_A = 33'sd1686629713;
   localparam logic signed [MUL_W-1:0] SIN_B = 33'sd688904866;
   localparam logic signed [MUL_W-1:0] SIN_C = 33'sd76016977;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3, ST_SIN4,
      ST_LG0, ST_LG1, ST_LG2, ST_LG3,
      ST_DIV0, ST_DIV1,
      ST_CH0, ST_CH1, ST_ST0, ST_ST1,
      ST_HP0, ST_HP1, ST_MX0, ST_MX1,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      RET_LFO,
      RET_SN,
      RET_CS
   } sin_ret_type;

   // 2^(k/16), Q30
   function automatic logic [31:0] exp2_tab(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:    r = 32'd1073741824;
         5'd1:    r = 32'd1121280435;
         5'd2:    r = 32'd1170923762;
         5'd3:    r = 32'd1222764977;
         5'd4:    r = 32'd1276901417;
         5'd5:    r = 32'd1333434673;
         5'd6:    r = 32'd1392470869;
         5'd7:    r = 32'd1454120819;
         5'd8:    r = 32'd1518500250;
         5'd9:    r = 32'd1585729998;
         5'd10:   r = 32'd1655936264;
         5'd11:   r = 32'd1729251204;
         5'd12:   r = 32'd1805811301;
         5'd13:   r = 32'd1885485267;
         5'd14:   r = 32'd1969251187;
         5'd15:   r = 32'd2056437386;
         default: r = 32'd2147483648;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -40'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [39:0] v);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      logic signed [SAMPLE_BITS-1:0] r;
      hi = (40'sd1 <<< (SAMPLE_BITS - 1)) - 40'sd1;
      lo = -(40'sd1 <<< (SAMPLE_BITS - 1));
      if (v > hi) r = hi[SAMPLE_BITS-1:0];
      else if (v < lo) r = lo[SAMPLE_BITS-1:0];
      else r = v[SAMPLE_BITS-1:0];
      return r;
   endfunction

endpackage

// ----- src/swept_allpass_phaser.sv -----
// Stereo phaser: LFO-swept chain of first-order all-pass stages, one shared multiplier.
// Each frame runs in order: the LFO sine, cutoff mapping, the sine and cosine of the
// cutoff phase, the coefficient divider, the left then the right channel, the load.
// A new input frame is taken only when idle, so not before the previous result beat
// is loaded; that load waits while a pending result beat is not taken.
// Reset: synchronous, clears LFO phase, filter state, control and sets register defaults.
module swept_allpass_phaser
   import sap_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [47:0]            req_tdata,   // left_sample[23:0], right_sample[47:24]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,   // left_out[23:0], right_out[47:24]
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type state_ff, state_in;

   // configuration
   logic [23:0]        phase_step_ff;
   logic [14:0]        sweep_depth_ff, feedback_gain_ff, wet_mix_ff, highpass_coef_ff;
   logic signed [17:0] center_log2_ff, floor_log2_ff;

   // working registers
   logic [31:0]                   phase_ff, sin_arg_ff, p_ff;
   sin_ret_type                   ret_ff;
   logic [16:0]                   x_ff, x2_ff, lb_ff;
   logic                          neg_ff, ch_ff;
   logic signed [32:0]            s_ff, sn_ff, cs_ff, a_ff, wet_ff;
   logic [STAGE_W-1:0]            k_ff;
   logic signed [31:0]            acc_ff;
   logic signed [40:0]            dry_ff;
   logic signed [SAMPLE_BITS-1:0] in_l_ff, in_r_ff, out_l_ff, out_r_ff;
   logic [47:0]                   rsp_data_ff;
   logic                          rsp_valid_ff;

   logic signed [31:0] in_mem_ff  [MEM_DEPTH];
   logic signed [31:0] out_mem_ff [MEM_DEPTH];
   logic signed [31:0] fb_ff [2];
   logic signed [31:0] lp_ff [2];

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic                     div_start, div_busy;
   logic [63:0]              div_num;
   logic [31:0]              div_den, div_quo;

   // combinational datapath
   logic [15:0]                   sin_r;
   logic [16:0]                   sin_x;
   logic [31:0]                   sin_m;
   logic signed [32:0]            sin_res;
   logic signed [19:0]            lg_raw, lg_f, lg_c, lb_full;
   logic [3:0]                    tab_idx;
   logic [31:0]                   tab_lo, tab_diff, exp_m, p_new;
   logic [4:0]                    nsh;
   logic signed [33:0]            sc_diff, sc_sum;
   logic [31:0]                   diff_mag;
   logic [MEM_W-1:0]              mem_idx;
   logic signed [SAMPLE_BITS-1:0] x_cur;
   logic signed [32:0]            d_stage, d_hp;
   logic signed [31:0]            acc_new, y_stage, lp_new;
   logic signed [51:0]            mix_sum;
   logic signed [SAMPLE_BITS-1:0] out_new;
   logic signed [32:0]            a_new;

   sap_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   sap_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   assign sin_r   = sin_arg_ff[29:14];
   assign sin_x   = sin_arg_ff[30] ? 17'd65536 - {1'b0, sin_r} : {1'b0, sin_r};
   assign sin_m   = prod[47:16];
   assign sin_res = neg_ff ? -$signed({1'b0, sin_m}) : $signed({1'b0, sin_m});

   assign lg_raw  = 20'(center_log2_ff) + prod[49:30];
   assign lg_f    = (lg_raw < 20'(floor_log2_ff)) ? 20'(floor_log2_ff) : lg_raw;
   assign lg_c    = (lg_f > CEIL_LOG2) ? CEIL_LOG2 : lg_f;
   assign lb_full = lg_c + LOG_BIAS;

   assign tab_idx  = lb_ff[12:9];
   assign tab_lo   = exp2_tab({1'b0, tab_idx});
   assign tab_diff = exp2_tab(5'({1'b0, tab_idx} + 5'd1)) - tab_lo;
   assign nsh      = 5'd16 - {1'b0, lb_ff[16:13]};
   assign exp_m    = tab_lo + prod[40:9];
   assign p_new    = exp_m >> nsh;

   assign sc_diff  = 34'(sn_ff) - 34'(cs_ff);
   assign sc_sum   = 34'(sn_ff) + 34'(cs_ff);
   assign diff_mag = sc_diff[33] ? 32'(-sc_diff) : sc_diff[31:0];
   assign div_num  = {2'b00, diff_mag, 30'd0};
   assign div_den  = (sc_sum <= 34'sd0) ? 32'd1 : sc_sum[31:0];
   assign a_new    = sc_diff[33] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

   assign mem_idx = ch_ff ? MEM_W'(STAGES + int'(k_ff)) : MEM_W'(k_ff);
   assign x_cur   = ch_ff ? in_r_ff : in_l_ff;
   assign d_stage = 33'(acc_ff) - 33'(out_mem_ff[mem_idx]);
   assign d_hp    = 33'(acc_ff) - 33'(lp_ff[ch_ff]);
   assign acc_new = sat32(40'(x_cur) + 40'(prod[54:15]));
   assign y_stage = sat32(40'($signed(prod[65:30])) + 40'(in_mem_ff[mem_idx]));
   assign lp_new  = sat32(40'(lp_ff[ch_ff]) + 40'(prod[54:15]));
   assign mix_sum = 52'(dry_ff) + prod[51:0];
   assign out_new = sat_out(40'($signed(mix_sum[51:15])));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_SIN0;
         ST_SIN0: state_in = ST_SIN1;
         ST_SIN1: state_in = ST_SIN2;
         ST_SIN2: state_in = ST_SIN3;
         ST_SIN3: state_in = ST_SIN4;
         ST_SIN4: begin
            unique case (ret_ff)
               RET_LFO: state_in = ST_LG0;
               RET_SN:  state_in = ST_SIN0;
               default: state_in = ST_DIV0;
            endcase
         end
         ST_LG0:  state_in = ST_LG1;
         ST_LG1:  state_in = ST_LG2;
         ST_LG2:  state_in = ST_LG3;
         ST_LG3:  state_in = ST_SIN0;
         ST_DIV0: state_in = ST_DIV1;
         ST_DIV1: if (!div_busy) state_in = ST_CH0;
         ST_CH0:  state_in = ST_CH1;
         ST_CH1:  state_in = ST_ST0;
         ST_ST0:  state_in = ST_ST1;
         ST_ST1:  state_in = (k_ff == STAGE_W'(STAGES - 1)) ? ST_HP0 : ST_ST0;
         ST_HP0:  state_in = ST_HP1;
         ST_HP1:  state_in = ST_MX0;
         ST_MX0:  state_in = ST_MX1;
         ST_MX1:  state_in = ch_ff ? ST_FIN : ST_CH0;
         ST_FIN:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: multiplier operands, divider start, handshake
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SIN0: begin
            mul_a = 33'(sin_x);
            mul_b = 33'(sin_x);
         end
         ST_SIN1: begin
            mul_a = SIN_C;
            mul_b = 33'(prod[32:16]);
         end
         ST_SIN2: begin
            mul_a = SIN_B - 33'(prod[42:16]);
            mul_b = 33'(x2_ff);
         end
         ST_SIN3: begin
            mul_a = SIN_A - 33'(prod[45:16]);
            mul_b = 33'(x_ff);
         end
         ST_LG0: begin
            mul_a = 33'(sweep_depth_ff);
            mul_b = s_ff;
         end
         ST_LG2: begin
            mul_a = 33'(tab_diff);
            mul_b = 33'(lb_ff[8:0]);
         end
         ST_DIV0: div_start = 1'b1;
         ST_CH0: begin
            mul_a = 33'(fb_ff[ch_ff]);
            mul_b = 33'(feedback_gain_ff);
         end
         ST_ST0: begin
            mul_a = a_ff;
            mul_b = d_stage;
         end
         ST_HP0: begin
            mul_a = d_hp;
            mul_b = 33'(highpass_coef_ff);
         end
         ST_HP1: begin
            mul_a = 33'(x_cur);
            mul_b = 33'(17'd32768 - {2'b00, wet_mix_ff});
         end
         ST_MX0: begin
            mul_a = wet_ff;
            mul_b = 33'({wet_mix_ff, 1'b0});
         end
         default: ;
      endcase
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= 24'd683565;
         sweep_depth_ff   <= 15'd12288;
         center_log2_ff   <= -18'sd56581;
         floor_log2_ff    <= -18'sd83794;
         feedback_gain_ff <= 15'd13107;
         wet_mix_ff       <= 15'd9830;
         highpass_coef_ff <= 15'd363;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_STEP:    phase_step_ff    <= csr_wdata;
            CSR_SWEEP_DEPTH:   sweep_depth_ff   <= csr_wdata[14:0];
            CSR_CENTER_LOG2:   center_log2_ff   <= csr_wdata[17:0];
            CSR_FLOOR_LOG2:    floor_log2_ff    <= csr_wdata[17:0];
            CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_wdata[14:0];
            CSR_WET_MIX:       wet_mix_ff       <= csr_wdata[14:0];
            CSR_HIGHPASS_COEF: highpass_coef_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         ch_ff        <= 1'b0;
         k_ff         <= '0;
         ret_ff       <= RET_LFO;
         for (int i = 0; i < MEM_DEPTH; i++) begin
            in_mem_ff[i]  <= '0;
            out_mem_ff[i] <= '0;
         end
         for (int c = 0; c < 2; c++) begin
            fb_ff[c] <= '0;
            lp_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         // FIN loads the next beat itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_FIN) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_tvalid) begin
               phase_ff   <= phase_ff + 32'(phase_step_ff);
               sin_arg_ff <= phase_ff + 32'(phase_step_ff);
               ret_ff     <= RET_LFO;
               ch_ff      <= 1'b0;
               in_l_ff    <= req_tdata[23:0];
               in_r_ff    <= req_tdata[47:24];
            end
            ST_SIN0: begin
               x_ff   <= sin_x;
               neg_ff <= sin_arg_ff[31];
            end
            ST_SIN1: x2_ff <= prod[32:16];
            ST_SIN4: begin
               unique case (ret_ff)
                  RET_LFO: s_ff <= sin_res;
                  RET_SN: begin
                     sn_ff      <= sin_res;
                     sin_arg_ff <= p_ff + 32'h4000_0000;
                     ret_ff     <= RET_CS;
                  end
                  default: cs_ff <= sin_res;
               endcase
            end
            ST_LG1: lb_ff <= lb_full[16:0];
            ST_LG3: begin
               p_ff       <= p_new;
               sin_arg_ff <= p_new;
               ret_ff     <= RET_SN;
            end
            ST_DIV1: if (!div_busy) a_ff <= a_new;
            ST_CH1: begin
               acc_ff <= acc_new;
               k_ff   <= '0;
            end
            ST_ST1: begin
               in_mem_ff[mem_idx]  <= acc_ff;
               out_mem_ff[mem_idx] <= y_stage;
               acc_ff              <= y_stage;
               if (k_ff != STAGE_W'(STAGES - 1)) k_ff <= k_ff + 1'b1;
            end
            ST_HP0: fb_ff[ch_ff] <= acc_ff;
            ST_HP1: begin
               lp_ff[ch_ff] <= lp_new;
               wet_ff       <= 33'(acc_ff) - 33'(lp_new);
            end
            ST_MX0: dry_ff <= prod[40:0];
            ST_MX1: begin
               if (ch_ff) begin
                  out_r_ff <= out_new;
               end else begin
                  out_l_ff <= out_new;
                  ch_ff    <= 1'b1;
               end
            end
            ST_FIN: if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_ff  <= {out_r_ff, out_l_ff};
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy) else $error("divider restarted while busy");

   a_accept_starts_lfo: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SIN0 && ret_ff == RET_LFO))
      else $error("accepted beat did not start the LFO sine");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CH0) |-> (a_ff <= 33'sd1073741824 && a_ff >= -33'sd1073741824))
      else $error("all-pass coefficient out of range");

   a_fin_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("pending result beat overwritten");

endmodule

// ----- src/sap_mul.sv -----
// Shared signed multiplier with a registered product.
module sap_mul
   import sap_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- src/sap_div.sv -----
// Restoring divider, one quotient bit per cycle.
module sap_div
   import sap_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [2*DIV_W-1:0] num,
   input  logic [DIV_W-1:0]   den,
   output logic               busy,
   output logic [DIV_W-1:0]   quo
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] low_ff, low_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   // remainder starts from the upper half, which is below den
   assign trial = {rem_ff, low_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = CNT_W'(DIV_W);
         rem_in = num[2*DIV_W-1:DIV_W];
         low_in = num[DIV_W-1:0];
         den_in = den;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = fits ? DIV_W'(trial - {1'b0, den_ff}) : trial[DIV_W-1:0];
         low_in = {low_ff[DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign busy = cnt_ff != '0;
   assign quo  = low_ff;

endmodule

// ----- tb/swept_allpass_phaser_test.sv -----
// Self-checking testbench for the swept all-pass phaser over several register settings.
`timescale 1ns / 1ps

module swept_allpass_phaser_test;
   import sap_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 120;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam longint unsigned POLY_A = 64'd1686629713;
   localparam longint unsigned POLY_B = 64'd688904866;
   localparam longint unsigned POLY_C = 64'd76016977;
   localparam longint unsigned OCT_TAB [0:16] = '{
      64'd1073741824, 64'd1121280435, 64'd1170923762, 64'd1222764977,
      64'd1276901417, 64'd1333434673, 64'd1392470869, 64'd1454120819,
      64'd1518500250, 64'd1585729998, 64'd1655936264, 64'd1729251204,
      64'd1805811301, 64'd1885485267, 64'd1969251187, 64'd2056437386,
      64'd2147483648};

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [47:0]            req_tdata;   // left_sample[23:0], right_sample[47:24]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [47:0]            rsp_tdata;   // left_out[23:0], right_out[47:24]
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   swept_allpass_phaser DUT (.*);

   // register copies
   logic [23:0] step_reg;
   logic [14:0] depth_reg, fbk_gain_reg, mix_reg, hp_coef_reg;
   longint      center_reg, floor_reg;
   // filter state copies
   logic [31:0] lfo_acc;
   longint      ap_in_mem [0:MEM_DEPTH-1];
   longint      ap_out_mem [0:MEM_DEPTH-1];
   longint      loop_out [0:1];
   longint      lowpass_out [0:1];

   logic [47:0] frame_queue [$];
   logic [47:0] expected_frames [$];
   bit          req_fire, rsp_fire, no_gaps, failed;
   int          req_gap, rsp_gap, stall_count, frames_checked, mismatches, settings_run;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint sine_q30(logic [31:0] ph);
      longint unsigned r, x, x2, t, v, m;
      r  = ph[29:14];
      x  = ph[30] ? 64'd65536 - r : r;
      x2 = (x * x) >> 16;
      t  = (POLY_C * x2) >> 16;
      v  = ((POLY_B - t) * x2) >> 16;
      m  = ((POLY_A - v) * x) >> 16;
      return ph[31] ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // advances the LFO and filter copies by one frame, returns the output beat
   function automatic logic [47:0] phase_frame(logic [47:0] frame);
      longint lg, lb, nsh, frac, idx, rem, sn, cs, den, coef, x, acc, d, y, lp, wet;
      longint unsigned m;
      logic [31:0] half_turn;
      logic signed [23:0] smp;
      logic [47:0] res;
      lfo_acc = lfo_acc + 32'(step_reg);
      lg = center_reg + ((longint'(depth_reg) * sine_q30(lfo_acc)) >>> 30);
      if (lg < floor_reg) lg = floor_reg;
      if (lg > longint'(CEIL_LOG2)) lg = CEIL_LOG2;
      lb   = lg + 139264;
      nsh  = 16 - ((lb >> 13) & 15);
      frac = lb & 8191;
      idx  = frac >> 9;
      rem  = frac & 511;
      m = OCT_TAB[idx] + (((OCT_TAB[idx+1] - OCT_TAB[idx]) * longint'(rem)) >> 9);
      half_turn = 32'(m >> nsh);
      sn  = sine_q30(half_turn);
      cs  = sine_q30(half_turn + 32'h4000_0000);
      den = sn + cs;
      if (den <= 0) den = 1;
      coef = ((sn - cs) * (64'sd1 <<< 30)) / den;
      for (int ch = 0; ch < 2; ch++) begin
         smp = frame[24*ch +: 24];
         x   = smp;
         acc = clip32(x + ((loop_out[ch] * longint'(fbk_gain_reg)) >>> 15));
         for (int k = 0; k < STAGES; k++) begin
            d = acc - ap_out_mem[ch*STAGES+k];
            y = clip32(((coef * d) >>> 30) + ap_in_mem[ch*STAGES+k]);
            ap_in_mem[ch*STAGES+k]  = acc;
            ap_out_mem[ch*STAGES+k] = y;
            acc = y;
         end
         loop_out[ch] = acc;
         lp = lowpass_out[ch];
         lp = clip32(lp + (((acc - lp) * longint'(hp_coef_reg)) >>> 15));
         lowpass_out[ch] = lp;
         wet = acc - lp;
         y = (x * (32768 - longint'(mix_reg)) + wet * 2 * longint'(mix_reg)) >>> 15;
         if (y > 8388607) y = 8388607;
         if (y < -8388608) y = -8388608;
         res[24*ch +: 24] = 24'(y);
      end
      return res;
   endfunction

   // input side driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // hold beat until taken
      end else if (req_gap > 0) begin
         req_gap = req_gap - 1;
         req_tvalid <= 1'b0;
      end else if (frame_queue.size() > 0) begin
         if (!no_gaps && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(0, 2);
            req_tvalid <= 1'b0;
         end else begin
            req_tdata  <= frame_queue.pop_front();
            req_tvalid <= 1'b1;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
         rsp_gap = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      req_fire = req_tvalid && req_tready && !reset;
      rsp_fire = rsp_tvalid && rsp_tready && !reset;
      if (req_fire) expected_frames.push_back(phase_frame(req_tdata));
      if (rsp_fire) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_tdata);
            failed = 1'b1;
         end else begin
            logic [47:0] want;
            want = expected_frames.pop_front();
            frames_checked++;
            for (int ch = 0; ch < 2; ch++)
               if (rsp_tdata[24*ch +: 24] !== want[24*ch +: 24]) begin
                  $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                           ch ? "right_out" : "left_out",
                           $signed(want[24*ch +: 24]), $signed(rsp_tdata[24*ch +: 24]));
                  failed = 1'b1;
                  mismatches++;
               end
         end
      end
      if (req_fire || rsp_fire || reset) stall_count = 0;
      else stall_count++;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, %0d beats outstanding", $time, expected_frames.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, longint val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 24'(val);
      case (idx)
         CSR_PHASE_STEP:    step_reg     = 24'(val);
         CSR_SWEEP_DEPTH:   depth_reg    = 15'(val);
         CSR_CENTER_LOG2:   center_reg   = longint'($signed(18'(val)));
         CSR_FLOOR_LOG2:    floor_reg    = longint'($signed(18'(val)));
         CSR_FEEDBACK_GAIN: fbk_gain_reg = 15'(val);
         CSR_WET_MIX:       mix_reg      = 15'(val);
         CSR_HIGHPASS_COEF: hp_coef_reg  = 15'(val);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      while (frame_queue.size() > 0 || req_tvalid || expected_frames.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(longint st, longint dp, longint ce, longint fl,
                                longint fb, longint mx, longint hp);
      drain();
      write_reg(CSR_PHASE_STEP, st);
      write_reg(CSR_SWEEP_DEPTH, dp);
      write_reg(CSR_CENTER_LOG2, ce);
      write_reg(CSR_FLOOR_LOG2, fl);
      write_reg(CSR_FEEDBACK_GAIN, fb);
      write_reg(CSR_WET_MIX, mx);
      write_reg(CSR_HIGHPASS_COEF, hp);
      settings_run++;
   endtask

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 24'h7F_FFFF;
         1:       return 24'h80_0000;
         2:       return 24'($urandom_range(0, 255)) - 24'd128;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) frame_queue.push_back({pick_sample(), pick_sample()});
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      no_gaps = 1'b0;
      failed = 1'b0;
      req_gap = 0;
      rsp_gap = 0;
      stall_count = 0;
      frames_checked = 0;
      mismatches = 0;
      settings_run = 1;
      step_reg = 24'd683565;
      depth_reg = 15'd12288;
      center_reg = -56581;
      floor_reg = -83794;
      fbk_gain_reg = 15'd13107;
      mix_reg = 15'd9830;
      hp_coef_reg = 15'd363;
      lfo_acc = '0;
      for (int i = 0; i < MEM_DEPTH; i++) begin
         ap_in_mem[i] = 0;
         ap_out_mem[i] = 0;
      end
      loop_out = '{0, 0};
      lowpass_out = '{0, 0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames under reset defaults: full-scale corners and patterns
      frame_queue.push_back({24'h00_0000, 24'h00_0000});
      frame_queue.push_back({24'h7F_FFFF, 24'h7F_FFFF});
      frame_queue.push_back({24'h80_0000, 24'h80_0000});
      frame_queue.push_back({24'h80_0000, 24'h7F_FFFF});
      frame_queue.push_back({24'h7F_FFFF, 24'h80_0000});
      frame_queue.push_back({24'h00_0001, 24'hFF_FFFF});
      frame_queue.push_back({24'h55_5555, 24'hAA_AAAA});
      frame_queue.push_back({24'hAA_AAAA, 24'h55_5555});
      for (int i = 0; i < 8; i++)
         frame_queue.push_back(i[0] ? {24'h80_0000, 24'h7F_FFFF} : {24'h7F_FFFF, 24'h80_0000});
      queue_random(140);

      // all maxima: hard regeneration to reach loop saturation, mix near one
      load_settings(24'hFF_FFFF, 32767, 0, -131072, 32767, 32767, 32767);
      for (int i = 0; i < 12; i++)
         frame_queue.push_back(i[1] ? {24'h80_0000, 24'h80_0000} : {24'h7F_FFFF, 24'h7F_FFFF});
      queue_random(130);

      // minima but for the floor, which is set above the ceiling
      load_settings(0, 0, -131072, 0, 0, 0, 0);
      queue_random(130);

      // center above zero, unused register index ignored
      load_settings($urandom_range(0, 24'hFF_FFFF), 32767, 131071, -131072,
                    $urandom_range(0, 32767), 16384, $urandom_range(0, 32767));
      write_reg(CSR_UNUSED, 24'hFF_FFFF);
      queue_random(130);

      for (int ph = 0; ph < 3; ph++) begin
         load_settings($urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 32767),
                       -longint'($urandom_range(0, 131072)), -longint'($urandom_range(0, 131072)),
                       $urandom_range(0, 32767),
                       $urandom_range(0, 1) ? $urandom_range(0, 16384) : $urandom_range(0, 32767),
                       $urandom_range(0, 32767));
         if (ph == 2) no_gaps = 1'b1;
         queue_random(135);
      end

      drain();
      $display("Checked %0d stereo frames over %0d register settings (extremes, floor over",
               frames_checked, settings_run);
      $display("ceiling, positive center, saturating feedback), %0d field mismatches.",
               mismatches);
      if (!failed && expected_frames.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
